// ===== src/mm4x4_pkg.sv =====
// ----------------------------------------------------------------------------
// mm4x4_pkg
// Shared constants for the fixed-point square matrix multiplier and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4x4_pkg;

    localparam int DEF_MATRIX_DIM = 4;
    localparam int DEF_FRAC_BITS  = 16;

    // Fixed field widths of the stream beats.
    localparam int ELEM_W  = 32;
    localparam int IDX_W   = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== src/matrix4x4_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Loads a right and then a left square matrix of signed fixed-point elements
// and streams out their product, row by row, with saturation to 32 bits.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_*      in         one matrix element per beat, tuser restarts the load
//  m_*      out        one product element per beat, tlast on the final one
//
//  Loading accepts one beat per cycle while s_tready is high, 2*MATRIX_DIM^2 beats per pair.
//  The product uses a single shared multiply-accumulate fed by one read port
//  on each element memory; s_tready stays low until the last read is issued.
//  Each read passes the memory read, multiply and accumulate registers; each
//  finished sum then passes the scale and saturate output register.
//  Reset clears the control state only; the element memories are not cleared.
//  A stalled output freezes the multiply pipeline; loading carries on meanwhile once all reads are issued.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4x4_multiply #(
    parameter int MATRIX_DIM = mm4x4_pkg::DEF_MATRIX_DIM,
    parameter int FRAC_BITS  = mm4x4_pkg::DEF_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mm4x4_pkg::S_DATA_W-1:0] s_tdata,  // [31:0] elem_value
    input  wire logic                          s_tuser,  // [0] first_elem
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] prod_value, [33:32] row_index, [35:34] col_index, [39:36] zero
    output logic [mm4x4_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast,  // is_last
    output logic                               m_tuser   // [0] saturated
);
    import mm4x4_pkg::*;

    localparam int ELEMS  = MATRIX_DIM * MATRIX_DIM;
    localparam int AW     = $clog2(ELEMS);
    localparam int CW     = $clog2(2 * ELEMS + 1);
    localparam int DW     = $clog2(MATRIX_DIM);
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W + $clog2(MATRIX_DIM);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_COMP = 1'b1;

    logic state_reg;
    logic [CW-1:0] count_reg;

    logic [ELEM_W-1:0] right_mem [ELEMS];
    logic [ELEM_W-1:0] left_mem  [ELEMS];

    // ---------------- loading ----------------
    logic          s_beat;
    logic [CW-1:0] wr_idx;
    logic [CW-1:0] wr_idx_inc;
    logic          wr_right;

    assign s_tready   = (state_reg == ST_LOAD);
    assign s_beat     = s_tvalid && s_tready;
    assign wr_idx     = s_tuser ? '0 : count_reg;
    assign wr_idx_inc = wr_idx + CW'(1);
    assign wr_right   = (wr_idx < CW'(ELEMS));

    always_ff @(posedge clk)
    begin
        if (s_beat && wr_right)
        begin
            right_mem[wr_idx[AW-1:0]] <= s_tdata[ELEM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat && !wr_right)
        begin
            left_mem[AW'(wr_idx - CW'(ELEMS))] <= s_tdata[ELEM_W-1:0];
        end
    end

    // ---------------- issue counters ----------------
    logic          pipe_en;
    logic          issue;
    logic [DW-1:0] i_reg, j_reg, k_reg;
    logic [AW-1:0] row_base_reg;
    logic [AW-1:0] raddr_reg;
    logic [AW-1:0] laddr;
    logic          k_end, j_end, i_end;

    assign pipe_en = !m_tvalid || m_tready;
    assign issue   = (state_reg == ST_COMP) && pipe_en;
    assign laddr   = row_base_reg + AW'(k_reg);
    assign k_end   = (k_reg == DW'(MATRIX_DIM - 1));
    assign j_end   = (j_reg == DW'(MATRIX_DIM - 1));
    assign i_end   = (i_reg == DW'(MATRIX_DIM - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            row_base_reg <= '0;
            raddr_reg    <= '0;
        end
        else if (state_reg == ST_LOAD)
        begin
            if (s_beat)
            begin
                if (wr_idx_inc == CW'(2 * ELEMS))
                begin
                    count_reg    <= '0;
                    state_reg    <= ST_COMP;
                    i_reg        <= '0;
                    j_reg        <= '0;
                    k_reg        <= '0;
                    row_base_reg <= '0;
                    raddr_reg    <= '0;
                end
                else
                begin
                    count_reg <= wr_idx_inc;
                end
            end
        end
        else if (issue)
        begin
            if (k_end)
            begin
                k_reg <= '0;
                if (j_end)
                begin
                    j_reg        <= '0;
                    i_reg        <= i_reg + DW'(1);
                    row_base_reg <= row_base_reg + AW'(MATRIX_DIM);
                    raddr_reg    <= '0;
                    if (i_end)
                    begin
                        // All reads are issued; the memories may be reloaded.
                        state_reg <= ST_LOAD;
                    end
                end
                else
                begin
                    j_reg     <= j_reg + DW'(1);
                    raddr_reg <= AW'(j_reg) + AW'(1);
                end
            end
            else
            begin
                k_reg     <= k_reg + DW'(1);
                raddr_reg <= raddr_reg + AW'(MATRIX_DIM);
            end
        end
    end

    // ---------------- memory read stage ----------------
    logic signed [ELEM_W-1:0] l_rd_reg, r_rd_reg;
    logic                     v1_reg;
    logic                     t1_first_reg, t1_last_reg, t1_end_reg;
    logic [DW-1:0]            t1_i_reg, t1_j_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            l_rd_reg <= left_mem[laddr];
            r_rd_reg <= right_mem[raddr_reg];
        end
    end

    // ---------------- multiply and accumulate stages ----------------
    logic signed [PROD_W-1:0] prod_reg;
    logic                     v2_reg;
    logic                     t2_first_reg, t2_last_reg, t2_end_reg;
    logic [DW-1:0]            t2_i_reg, t2_j_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic                     sum_valid_reg;
    logic                     t3_end_reg;
    logic [DW-1:0]            t3_i_reg, t3_j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            sum_valid_reg <= v2_reg && t2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            t1_first_reg <= (k_reg == '0);
            t1_last_reg  <= k_end;
            t1_end_reg   <= i_end && j_end;
            t1_i_reg     <= i_reg;
            t1_j_reg     <= j_reg;

            prod_reg     <= PROD_W'(l_rd_reg) * PROD_W'(r_rd_reg);
            t2_first_reg <= t1_first_reg;
            t2_last_reg  <= t1_last_reg;
            t2_end_reg   <= t1_end_reg;
            t2_i_reg     <= t1_i_reg;
            t2_j_reg     <= t1_j_reg;

            if (v2_reg)
            begin
                acc_reg <= t2_first_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
            end
            t3_end_reg <= t2_end_reg;
            t3_i_reg   <= t2_i_reg;
            t3_j_reg   <= t2_j_reg;
        end
    end

    // ---------------- scale, saturate and output register ----------------
    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-ELEM_W:0]    upper;
    logic                     sat;
    logic [ELEM_W-1:0]        clamped;

    assign shifted = acc_reg >>> FRAC_BITS;
    assign upper   = shifted[ACC_W-1:ELEM_W-1];
    // The value fits when every bit from the sign of the 32-bit result up agrees.
    assign sat     = !((&upper) || !(|upper));
    assign clamped = sat ? (acc_reg[ACC_W-1] ? ELEM_MIN : ELEM_MAX) : shifted[ELEM_W-1:0];

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            m_tvalid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && sum_valid_reg)
        begin
            m_tdata_reg <= {(M_DATA_W - ELEM_W - 2 * IDX_W)'(0),
                            IDX_W'(t3_j_reg), IDX_W'(t3_i_reg), clamped};
            m_tlast_reg <= t3_end_reg;
            m_tuser_reg <= sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== src/mm4x4_check.sv =====
// ----------------------------------------------------------------------------
// mm4x4_check
// Port-level checks on the matrix multiplier streams, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4x4_check #(
    parameter int MATRIX_DIM = mm4x4_pkg::DEF_MATRIX_DIM
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mm4x4_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          m_tuser
);
    import mm4x4_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_DIM - 1);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The final beat of a product sits on the last row and column.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[33:32] == LAST_IDX && m_tdata[35:34] == LAST_IDX)
        else $error("tlast away from the last element");

    // A clamped result carries one of the two limit values.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[31:0] == ELEM_MAX || m_tdata[31:0] == ELEM_MIN)
        else $error("saturated beat without a limit value");

    // Once reset has been held across a clock edge, no result is offered.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !m_tvalid)
        else $error("result beat during reset");

    // The input ready is always driven to a known level out of reset.
    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(s_tready))
        else $error("input ready unknown");

endmodule

bind matrix4x4_multiply mm4x4_check #(.MATRIX_DIM(MATRIX_DIM)) u_mm4x4_check (.*);

`default_nettype wire

// ===== test/matrix4x4_multiply_check.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply_check
// Watches both streams of the matrix multiplier, keeps its own copy of the
// two element stores, computes every product element when a pair completes
// and compares each output beat against the oldest computed element.
// ----------------------------------------------------------------------------

module matrix4x4_multiply_check #(
    parameter int MATRIX_DIM = mm4x4_pkg::DEF_MATRIX_DIM,
    parameter int FRAC_BITS  = mm4x4_pkg::DEF_FRAC_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [mm4x4_pkg::S_DATA_W-1:0] s_tdata,  // [31:0] elem_value
    input  wire logic                           s_tuser,  // [0] first_elem
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] prod_value, [33:32] row_index, [35:34] col_index, [39:36] zero
    input  wire logic [mm4x4_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic                           m_tlast,  // is_last
    input  wire logic                           m_tuser,  // [0] saturated
    output int                                  error_count,
    output int                                  pending,
    output int                                  results_seen,
    output int                                  clamped_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import mm4x4_pkg::*;

    localparam int ELEMS = MATRIX_DIM * MATRIX_DIM;

    localparam logic signed [127:0] SUM_HI = 128'sd2147483647;
    localparam logic signed [127:0] SUM_LO = -128'sd2147483648;

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
        logic              clamped;
    } prod_beat_t;

    prod_beat_t prod_q[$];

    logic signed [ELEM_W-1:0] right_m [ELEMS];
    logic signed [ELEM_W-1:0] left_m  [ELEMS];
    int                       load_cnt;
    int                       err_n;
    int                       seen_n;
    int                       clamp_n;

    // The sum of four 64-bit products is exact in 128 bits; the arithmetic
    // shift rounds toward minus infinity before the clamp.
    function automatic logic [ELEM_W-1:0] product_elem(input int row, input int col,
                                                       output logic clamped);
        logic signed [127:0] acc;
        logic signed [63:0]  a;
        logic signed [63:0]  b;
        int                  k;
        acc = '0;
        for (k = 0; k < MATRIX_DIM; k++)
        begin
            a = left_m[row * MATRIX_DIM + k];
            b = right_m[k * MATRIX_DIM + col];
            acc = acc + a * b;
        end
        acc = acc >>> FRAC_BITS;
        clamped = 1'b1;
        if (acc > SUM_HI)
            return ELEM_MAX;
        if (acc < SUM_LO)
            return ELEM_MIN;
        clamped = 1'b0;
        return acc[ELEM_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        prod_beat_t got;
        prod_beat_t want;
        prod_beat_t beat;
        logic       clamped;
        int         i;
        int         j;
        if (!rst_n)
        begin
            load_cnt = 0;
            err_n    = 0;
            seen_n   = 0;
            clamp_n  = 0;
            prod_q.delete();
            error_count  <= 0;
            pending      <= 0;
            results_seen <= 0;
            clamped_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.value   = m_tdata[ELEM_W-1:0];
                got.row     = m_tdata[ELEM_W+IDX_W-1:ELEM_W];
                got.col     = m_tdata[ELEM_W+2*IDX_W-1:ELEM_W+IDX_W];
                got.last    = m_tlast;
                got.clamped = m_tuser;
                seen_n++;
                if (m_tuser)
                    clamp_n++;
                if (prod_q.size() == 0)
                begin
                    err_n++;
                    $display("%0t ns: product beat with none outstanding: data %h last %b sat %b",
                             $time, m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = prod_q.pop_front();
                    if (got !== want || m_tdata[M_DATA_W-1:ELEM_W+2*IDX_W] !== '0)
                    begin
                        err_n++;
                        $display("%0t ns: product mismatch: expected value %h row %0d col %0d",
                                 $time, want.value, want.row, want.col,
                                 " last %b sat %b pad 0", want.last, want.clamped);
                        $display("%0t ns:                   actual value %h row %0d col %0d",
                                 $time, got.value, got.row, got.col,
                                 " last %b sat %b pad %h", got.last, got.clamped,
                                 m_tdata[M_DATA_W-1:ELEM_W+2*IDX_W]);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser || load_cnt >= 2 * ELEMS)
                    load_cnt = 0;
                if (load_cnt < ELEMS)
                    right_m[load_cnt] = s_tdata[ELEM_W-1:0];
                else
                    left_m[load_cnt - ELEMS] = s_tdata[ELEM_W-1:0];
                load_cnt++;
                if (load_cnt == 2 * ELEMS)
                begin
                    load_cnt = 0;
                    for (i = 0; i < MATRIX_DIM; i++)
                    begin
                        for (j = 0; j < MATRIX_DIM; j++)
                        begin
                            beat.value   = product_elem(i, j, clamped);
                            beat.row     = i[IDX_W-1:0];
                            beat.col     = j[IDX_W-1:0];
                            beat.last    = (i == MATRIX_DIM - 1) && (j == MATRIX_DIM - 1);
                            beat.clamped = clamped;
                            prod_q.push_back(beat);
                        end
                    end
                end
            end

            error_count  <= err_n;
            pending      <= prod_q.size();
            results_seen <= seen_n;
            clamped_seen <= clamp_n;
        end
    end

endmodule

// ===== test/matrix4x4_multiply_test.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply_test
// Drives matrix pairs into the multiplier: a directed part that hits both
// saturation limits, rounding and restarts, then random pairs with broken
// loads, under changing idle patterns and one long output stall.
// ----------------------------------------------------------------------------

module matrix4x4_multiply_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mm4x4_pkg::*;

    localparam int ELEMS        = DEF_MATRIX_DIM * DEF_MATRIX_DIM;
    localparam int RANDOM_ITEMS = 340;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [ELEM_W-1:0] FIX_ONE  = 32'h0001_0000;
    localparam logic [ELEM_W-1:0] FIX_HALF = 32'h0000_8000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    int error_count;
    int pending;
    int results_seen;
    int clamped_seen;

    int phase = 0;
    int items_sent = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    logic [ELEM_W-1:0] rmat [ELEMS];
    logic [ELEM_W-1:0] lmat [ELEMS];

    matrix4x4_multiply u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    matrix4x4_multiply_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .error_count  (error_count),
        .pending      (pending),
        .results_seen (results_seen),
        .clamped_seen (clamped_seen)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int idle_pct(input int ph, input bit sink);
        case (ph)
            0:       return sink ? 83 : 10;
            1:       return sink ? 10 : 83;
            default: return 0;
        endcase
    endfunction

    // Mix of extremes, zero, full-range words and small values within +-4.0.
    function automatic logic [ELEM_W-1:0] rand_elem();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return ELEM_MAX;
            1:       return ELEM_MIN;
            2:       return '0;
            3, 4, 5: return r;
            default: return {{13{r[18]}}, r[18:0]};
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_elem(input logic [ELEM_W-1:0] value, input logic restart);
        while ($urandom_range(0, 99) < idle_pct(phase, 1'b0))
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= $urandom_range(0, 1);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_pair(input logic restart);
        int k;
        for (k = 0; k < ELEMS; k++)
            send_elem(rmat[k], (k == 0) ? restart : 1'b0);
        for (k = 0; k < ELEMS; k++)
            send_elem(lmat[k], 1'b0);
    endtask

    // Output side: random back-pressure, plus one long hold-off when the
    // no-idle phase begins so the block fills up and stalls its input.
    always @(negedge clk)
    begin
        if (phase == 2 && !hold_done)
        begin
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES)
                hold_done = 1'b1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= idle_pct(phase, 1'b1));
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        int  k;
        int  kind;
        int  len;
        int  rand_start;
        bit  prev_broken;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Right operand all maximum. Left rows: all maximum (clamps high),
        // all minimum (clamps low), 1.0 in the first column (lands exactly
        // on the maximum without clamping), zero.
        for (k = 0; k < ELEMS; k++)
        begin
            rmat[k] = ELEM_MAX;
            case (k / DEF_MATRIX_DIM)
                0:       lmat[k] = ELEM_MAX;
                1:       lmat[k] = ELEM_MIN;
                2:       lmat[k] = (k % DEF_MATRIX_DIM == 0) ? FIX_ONE : '0;
                default: lmat[k] = '0;
            endcase
        end
        send_pair(1'b1);

        // Right operand all minimum, sent without the restart flag right
        // after a finished pair. Rows: minimum squared clamps high, -1.0
        // lands one step above the maximum, 1.0 gives the minimum exactly,
        // and the smallest negative step.
        for (k = 0; k < ELEMS; k++)
        begin
            rmat[k] = ELEM_MIN;
            case (k / DEF_MATRIX_DIM)
                0:       lmat[k] = ELEM_MIN;
                1:       lmat[k] = (k % DEF_MATRIX_DIM == 0) ? -FIX_ONE : '0;
                2:       lmat[k] = (k % DEF_MATRIX_DIM == 0) ? FIX_ONE : '0;
                default: lmat[k] = 32'hFFFF_FFFF;
            endcase
        end
        send_pair(1'b0);

        // An abandoned partial load, then a restart with 0.5 on the diagonal
        // against small odd negatives, which rounds toward minus infinity.
        for (k = 0; k < 10; k++)
            send_elem(rand_elem(), 1'b0);
        for (k = 0; k < ELEMS; k++)
        begin
            rmat[k] = (k % (DEF_MATRIX_DIM + 1) == 0) ? FIX_HALF : '0;
            lmat[k] = -(2 * $urandom_range(0, 20) + 1);
        end
        send_pair(1'b1);

        rand_start  = items_sent;
        prev_broken = 1'b1;
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 2)
            begin
                // Load cut short; the next sequence restarts.
                len = $urandom_range(1, 2 * ELEMS - 1);
                for (k = 0; k < len; k++)
                    send_elem(rand_elem(), k == 0);
                prev_broken = 1'b1;
            end
            else if (kind == 2)
            begin
                // A burst of items that each restart the load.
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    send_elem(rand_elem(), 1'b1);
                prev_broken = 1'b1;
            end
            else
            begin
                for (k = 0; k < ELEMS; k++)
                begin
                    rmat[k] = rand_elem();
                    lmat[k] = rand_elem();
                end
                send_pair(prev_broken ? 1'b1 : logic'($urandom_range(0, 1)));
                prev_broken = 1'b0;
            end
            if (items_sent - rand_start >= 2 * RANDOM_ITEMS / 3)
                phase <= 2;
            else if (items_sent - rand_start >= RANDOM_ITEMS / 3)
                phase <= 1;
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input beats: directed clamp and rounding pairs,", items_sent,
                 " restarts, random pairs under three idle patterns and a long output stall.");
        $display("%0d product beats checked, %0d of them saturated.", results_seen,
                 clamped_seen);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
